// File: hw/rtl/jlss_pkg.sv
package jlss_pkg;

  localparam int DEF_MAX_ROW_LENGTH = 4096;
  localparam int DEF_VALUE_BITS     = 24;

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 13;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT  = 2'd1;

  // grid dimensions
  localparam int MIN_DIM       = 3;
  localparam int ROW_COUNT_MAX = 4096;
  localparam int ROW_BITS      = 12;
  localparam int CNT_BITS      = 13;

  // per-transaction control from the position tracker
  typedef struct packed {
    logic frame_start;
    logic emit;
    logic last;
  } pos_flags_t;

endpackage

// File: hw/rtl/jlss_position.sv
module jlss_position #(
  parameter int MAX_ROW_LENGTH = jlss_pkg::DEF_MAX_ROW_LENGTH,
  parameter int COL_W          = $clog2(MAX_ROW_LENGTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [jlss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [jlss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                advance,
  output logic [COL_W-1:0]                    col,
  output jlss_pkg::pos_flags_t                flags
);

  localparam int LEN_W   = $clog2(MAX_ROW_LENGTH + 1);
  localparam int CMP_W   = (LEN_W > jlss_pkg::CFG_DATA_BITS) ? LEN_W : jlss_pkg::CFG_DATA_BITS;
  localparam int LEN_RST = (MAX_ROW_LENGTH < 4096) ? MAX_ROW_LENGTH : 4096;
  localparam int CNT_W   = jlss_pkg::CNT_BITS;
  localparam int ROW_W   = jlss_pkg::ROW_BITS;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic [CMP_W-1:0] data_x;
  logic             wrap;
  logic [CNT_W-1:0] r_pre;
  logic [ROW_W-1:0] r_cur;
  logic [COL_W-1:0] c_cur;
  logic [LEN_W-1:0] c_inc;
  logic [CNT_W-1:0] r_inc;
  logic             col_end;
  logic             row_end;

  // configuration writes, clamped on the way in
  always_comb begin
    data_x  = CMP_W'(cfg_data);
    len_nxt = len_r;
    cnt_nxt = cnt_r;
    if (cfg_we && cfg_index == jlss_pkg::CFG_ROW_LENGTH) begin
      if (data_x < CMP_W'(jlss_pkg::MIN_DIM)) begin
        len_nxt = LEN_W'(jlss_pkg::MIN_DIM);
      end else if (data_x > CMP_W'(MAX_ROW_LENGTH)) begin
        len_nxt = LEN_W'(MAX_ROW_LENGTH);
      end else begin
        len_nxt = LEN_W'(data_x);
      end
    end
    if (cfg_we && cfg_index == jlss_pkg::CFG_ROW_COUNT) begin
      if (cfg_data < CNT_W'(jlss_pkg::MIN_DIM)) begin
        cnt_nxt = CNT_W'(jlss_pkg::MIN_DIM);
      end else if (cfg_data > CNT_W'(jlss_pkg::ROW_COUNT_MAX)) begin
        cnt_nxt = CNT_W'(jlss_pkg::ROW_COUNT_MAX);
      end else begin
        cnt_nxt = cfg_data;
      end
    end
  end

  // position of the incoming cell; a shrunk size forces a new row or frame
  always_comb begin
    wrap    = LEN_W'(col_r) >= len_r;
    c_cur   = wrap ? '0 : col_r;
    r_pre   = wrap ? CNT_W'(row_r) + CNT_W'(1) : CNT_W'(row_r);
    r_cur   = (r_pre >= cnt_r) ? '0 : ROW_W'(r_pre);
    c_inc   = LEN_W'(c_cur) + LEN_W'(1);
    r_inc   = CNT_W'(r_cur) + CNT_W'(1);
    col_end = c_inc >= len_r;
    row_end = r_inc >= cnt_r;
    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : ROW_W'(r_inc);
    end else begin
      col_nxt = COL_W'(c_inc);
      row_nxt = r_cur;
    end
    flags.frame_start = (r_cur == '0) && (c_cur == '0);
    flags.emit        = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
    flags.last        = col_end && row_end;
  end

  assign col = c_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(LEN_RST);
      cnt_r <= CNT_W'(jlss_pkg::ROW_COUNT_MAX);
      col_r <= '0;
      row_r <= '0;
    end else begin
      len_r <= len_nxt;
      cnt_r <= cnt_nxt;
      if (advance) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/jacobi_laplace_stencil_sweep_top.sv
// channel  direction  handshake                 payload
// in       input      in_valid / in_stall       in_cell_value
// out      output     out_valid / out_stall     out_new_value, out_change_max, out_frame_last
// cfg      input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one cell per cycle sustained while the output is not stalled; a cell goes through two
// register stages: the row-store read register, then the result register.
// the combined row store has one read and one write port, which sets the rate.
// rst_n clears position, config, window and running max; row stores are not cleared.
// out_stall backs up through the stage register into in_stall in the same cycle.
// cfg_ready is always high.
module jacobi_laplace_stencil_sweep_top #(
  parameter int MAX_ROW_LENGTH = jlss_pkg::DEF_MAX_ROW_LENGTH,
  parameter int VALUE_BITS     = jlss_pkg::DEF_VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [VALUE_BITS-1:0]               in_cell_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [VALUE_BITS-1:0]               out_new_value,
  output logic [VALUE_BITS-1:0]               out_change_max,
  output logic                                out_frame_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jlss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [jlss_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int COL_W = $clog2(MAX_ROW_LENGTH);
  localparam int VB    = VALUE_BITS;

  logic                 accept;
  logic                 s1_adv;
  logic [COL_W-1:0]     col;
  jlss_pkg::pos_flags_t flags;

  // stage 1: cell and its position, row-store read data
  logic                 s1_valid_r;
  logic [COL_W-1:0]     s1_col_r;
  logic [VB-1:0]        s1_val_r;
  jlss_pkg::pos_flags_t s1_flags_r;
  logic [2*VB-1:0]      rd_r;

  // upper row in the high half, middle row in the low half
  logic [2*VB-1:0]      row_store_r [MAX_ROW_LENGTH];

  logic [VB-1:0] win1_r, win2_r;
  logic [VB-1:0] up_dly_r, dn_dly_r;
  logic [VB-1:0] max_r, max_nxt;

  logic          out_valid_r;
  logic [VB-1:0] out_new_value_r;
  logic [VB-1:0] out_change_max_r;
  logic          out_frame_last_r;

  logic [VB-1:0] up_now, mid_now;
  logic [VB+1:0] sum;
  logic [VB-1:0] new_val, diff, base;
  logic          load_out;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign accept    = in_valid && !in_stall;
  assign load_out  = s1_adv && s1_flags_r.emit;

  jlss_position #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
    .COL_W         (COL_W)
  ) u_position (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .advance  (accept),
    .col      (col),
    .flags    (flags)
  );

  // read at the new column, write back the previous transaction's column
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= row_store_r[col];
    end
    if (s1_adv) begin
      row_store_r[s1_col_r] <= {mid_now, s1_val_r};
    end
  end

  always_comb begin
    up_now  = rd_r[2*VB-1:VB];
    mid_now = rd_r[VB-1:0];
    // window after the shift: left = win1, centre = win2, right = mid_now
    sum     = (VB+2)'(up_dly_r) + (VB+2)'(dn_dly_r) + (VB+2)'(win1_r) + (VB+2)'(mid_now);
    new_val = sum[VB+1:2];
    diff    = (new_val > win2_r) ? (new_val - win2_r) : (win2_r - new_val);
    base    = s1_flags_r.frame_start ? '0 : max_r;
    max_nxt = (s1_flags_r.emit && diff > base) ? diff : base;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r   <= col;
      s1_val_r   <= in_cell_value;
      s1_flags_r <= flags;
    end
    if (load_out) begin
      out_new_value_r  <= new_val;
      out_change_max_r <= max_nxt;
      out_frame_last_r <= s1_flags_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      win1_r      <= '0;
      win2_r      <= '0;
      up_dly_r    <= '0;
      dn_dly_r    <= '0;
      max_r       <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      out_valid_r <= load_out || (out_valid_r && out_stall);
      if (s1_adv) begin
        win1_r   <= win2_r;
        win2_r   <= mid_now;
        up_dly_r <= up_now;
        dn_dly_r <= s1_val_r;
        max_r    <= max_nxt;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_value  = out_new_value_r;
  assign out_change_max = out_change_max_r;
  assign out_frame_last = out_frame_last_r;

endmodule

// File: tb/tb_jacobi_laplace_stencil_sweep_top.sv
module tb_jacobi_laplace_stencil_sweep_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB           = jlss_pkg::DEF_VALUE_BITS;
  localparam int ROW_MAX      = jlss_pkg::DEF_MAX_ROW_LENGTH;
  localparam int RANDOM_CELLS = 1650;

  // indexes with no register behind them
  localparam logic [jlss_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [jlss_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_B = 2'd3;

  typedef logic [VB-1:0] cell_t;
  typedef logic [jlss_pkg::CFG_DATA_BITS-1:0] dim_raw_t;
  typedef logic [jlss_pkg::CFG_INDEX_BITS-1:0] cfg_idx_t;

  localparam cell_t CELL_MAX = '1;

  typedef struct {
    cell_t new_value;
    cell_t change_max;
    logic  frame_last;
  } relaxed_t;

  class relaxation_tracker;
    dim_raw_t    len_reg;
    dim_raw_t    cnt_reg;
    cell_t       upper_row [ROW_MAX];
    cell_t       middle_row [ROW_MAX];
    cell_t       win [3];
    cell_t       up_d;
    cell_t       down_d;
    cell_t       run_max;
    int unsigned col;
    int unsigned row;
    relaxed_t    expected_relaxed [$];
    int unsigned mismatches;
    int unsigned cells;
    int unsigned results;
    int unsigned frames;

    function void clear();
      len_reg = dim_raw_t'(ROW_MAX);
      cnt_reg = dim_raw_t'(jlss_pkg::ROW_COUNT_MAX);
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      win = '{default: '0};
      up_d = '0;
      down_d = '0;
      run_max = '0;
      col = 0;
      row = 0;
      expected_relaxed.delete();
      mismatches = 0;
      cells = 0;
      results = 0;
      frames = 0;
    endfunction

    function int unsigned dim(dim_raw_t raw, int unsigned hi);
      if (raw < jlss_pkg::MIN_DIM) return jlss_pkg::MIN_DIM;
      if (raw > hi) return hi;
      return raw;
    endfunction

    function int unsigned row_len();
      return dim(len_reg, ROW_MAX);
    endfunction

    function int unsigned row_cnt();
      return dim(cnt_reg, jlss_pkg::ROW_COUNT_MAX);
    endfunction

    function void write_reg(cfg_idx_t idx, dim_raw_t data);
      if (idx == jlss_pkg::CFG_ROW_LENGTH) len_reg = data;
      else if (idx == jlss_pkg::CFG_ROW_COUNT) cnt_reg = data;
    endfunction

    // true when the next cell opens a frame, counting a wrap left pending by a shrink
    function bit at_frame_start();
      int unsigned c;
      int unsigned r;
      c = col;
      r = row;
      if (c >= row_len()) begin
        c = 0;
        r++;
      end
      if (r >= row_cnt()) r = 0;
      return (c == 0) && (r == 0);
    endfunction

    function void take_cell(cell_t v);
      int unsigned len;
      int unsigned cnt;
      cell_t       up_now;
      cell_t       mid_now;
      cell_t       nv;
      cell_t       centre;
      cell_t       diff;
      logic [VB+1:0] sum;
      relaxed_t    res;
      len = row_len();
      cnt = row_cnt();
      cells++;
      if (col >= len) begin
        col = 0;
        row++;
      end
      if (row >= cnt) row = 0;
      if (row == 0 && col == 0) begin
        run_max = '0;
        frames++;
      end
      up_now  = upper_row[col];
      mid_now = middle_row[col];
      win[0] = win[1];
      win[1] = win[2];
      win[2] = mid_now;
      if (row >= 2 && col >= 2) begin
        sum = {2'b00, up_d} + {2'b00, down_d} + {2'b00, win[0]} + {2'b00, win[2]};
        nv = sum[VB+1:2];
        centre = win[1];
        diff = (nv > centre) ? nv - centre : centre - nv;
        if (diff > run_max) run_max = diff;
        res.new_value  = nv;
        res.change_max = run_max;
        res.frame_last = (row == cnt - 1) && (col == len - 1);
        expected_relaxed.push_back(res);
      end
      up_d = up_now;
      down_d = v;
      upper_row[col]  = mid_now;
      middle_row[col] = v;
      col++;
      if (col >= len) begin
        col = 0;
        row++;
        if (row >= cnt) row = 0;
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_relaxed(cell_t nv, cell_t cm, logic fl);
      relaxed_t exp_r;
      if (expected_relaxed.size() == 0) begin
        report($sformatf("unexpected result new_value=%h change_max=%h frame_last=%b",
                         nv, cm, fl));
        return;
      end
      exp_r = expected_relaxed.pop_front();
      results++;
      if (nv !== exp_r.new_value || cm !== exp_r.change_max || fl !== exp_r.frame_last)
        report($sformatf("result %0d: got %h/%h/%b, wanted %h/%h/%b", results, nv, cm, fl,
                         exp_r.new_value, exp_r.change_max, exp_r.frame_last));
    endtask

    task close_out();
      if (expected_relaxed.size() != 0)
        report($sformatf("%0d results never arrived", expected_relaxed.size()));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  cell_t                     in_cell_value;
  logic                      out_valid;
  logic                      out_stall;
  cell_t                     out_new_value;
  cell_t                     out_change_max;
  logic                      out_frame_last;
  logic                      cfg_valid;
  logic                      cfg_ready;
  cfg_idx_t                  cfg_index;
  dim_raw_t                  cfg_data;
  bit                        idle_on;

  relaxation_tracker relax = new;

  jacobi_laplace_stencil_sweep_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_new_value  (out_new_value),
    .out_change_max (out_change_max),
    .out_frame_last (out_frame_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      relax.check_relaxed(out_new_value, out_change_max, out_frame_last);
  end

  // result side back-pressure in bursts
  initial begin : stall_gen
    bit          hold;
    int unsigned span;
    out_stall = 1'b0;
    forever begin
      hold = rst_n && idle_on && ($urandom_range(0, 3) == 0);
      span = hold ? $urandom_range(1, 10) : $urandom_range(1, 16);
      out_stall <= hold;
      repeat (span) @(posedge clk);
    end
  end

  function automatic cell_t rand_cell();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CELL_MAX;
      2: return cell_t'($urandom_range(0, 3));
      3: return CELL_MAX - cell_t'($urandom_range(0, 3));
      default: return cell_t'($urandom);
    endcase
  endfunction

  task automatic send_cell(input cell_t v);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cell_value <= v;
    do @(posedge clk); while (in_stall);
    relax.take_cell(v);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input dim_raw_t data, input bit done);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    relax.write_reg(idx, data);
    if (done) cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(input dim_raw_t raw_len, input dim_raw_t raw_cnt);
    cfg_write(jlss_pkg::CFG_ROW_LENGTH, raw_len, 1'b0);
    cfg_write(jlss_pkg::CFG_ROW_COUNT, raw_cnt, 1'b1);
  endtask

  // drain: all results in, then border cells still in the pipe get unstalled cycles
  task automatic settle();
    int unsigned quiet;
    in_valid <= 1'b0;
    while (relax.expected_relaxed.size() != 0) @(posedge clk);
    quiet = 0;
    while (quiet < 8) begin
      @(posedge clk);
      if (!out_stall) quiet++;
    end
  endtask

  initial begin : stimulus
    cell_t       v;
    int unsigned rand_sent;
    int unsigned pick;
    int unsigned len;
    int unsigned cnt;
    int unsigned total;
    int unsigned cut;
    int unsigned drain;
    dim_raw_t    raw_len;
    dim_raw_t    raw_cnt;
    relax.clear();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cell_value = '0;
    cfg_valid = 1'b0;
    cfg_index = jlss_pkg::CFG_ROW_LENGTH;
    cfg_data = '0;
    idle_on = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // below-minimum sizes clamp to a 3x3 grid with a single interior cell
    set_grid(dim_raw_t'(0), dim_raw_t'(2));
    for (int k = 0; k < 9; k++) send_cell(CELL_MAX);
    // centre at zero against full-scale neighbours gives the largest change
    for (int k = 0; k < 9; k++) begin
      v = (k == 4) ? '0 : CELL_MAX;
      send_cell(v);
    end
    settle();
    cfg_write(CFG_SPARE_A, '1, 1'b0);
    cfg_write(CFG_SPARE_B, dim_raw_t'($urandom), 1'b1);
    // neighbours sum to 5, so the mean truncates to 1
    for (int k = 0; k < 9; k++) begin
      case (k)
        1, 3, 5: v = cell_t'(1);
        7: v = cell_t'(2);
        4: v = cell_t'(24'h800000);
        default: v = '0;
      endcase
      send_cell(v);
    end

    // oversized writes clamp to the largest grid; a shrink in mid row forces an early wrap
    settle();
    set_grid('1, '1);
    for (int k = 0; k < 40; k++) send_cell(rand_cell());
    settle();
    set_grid(dim_raw_t'(4), dim_raw_t'(3));
    while (!relax.at_frame_start()) send_cell(rand_cell());

    rand_sent = 0;
    while (rand_sent < RANDOM_CELLS) begin
      settle();
      idle_on = (rand_sent < RANDOM_CELLS - 300) && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        len = $urandom_range(3, 10);
        cnt = $urandom_range(3, 9);
      end else if (pick < 7) begin
        len = $urandom_range(3, 5);
        cnt = $urandom_range(10, 24);
      end else if (pick < 9) begin
        len = $urandom_range(11, 32);
        cnt = $urandom_range(3, 6);
      end else begin
        len = $urandom_range(33, 64);
        cnt = $urandom_range(3, 4);
      end
      raw_len = dim_raw_t'(len);
      raw_cnt = dim_raw_t'(cnt);
      if (len == 3 && $urandom_range(0, 1) == 1) raw_len = dim_raw_t'($urandom_range(0, 2));
      if (cnt == 3 && $urandom_range(0, 1) == 1) raw_cnt = dim_raw_t'($urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0)
        cfg_write(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  dim_raw_t'($urandom), 1'b0);
      set_grid(raw_len, raw_cnt);
      total = len * cnt;
      cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, total - 1) : total;
      for (int unsigned k = 0; k < cut; k++) begin
        send_cell(rand_cell());
        rand_sent++;
      end
      if (cut < total) begin
        // resize in mid frame; rows only shrink so every column read later was written
        settle();
        set_grid(dim_raw_t'($urandom_range(0, relax.row_len())),
                 dim_raw_t'($urandom_range(0, 12)));
        while (!relax.at_frame_start()) begin
          send_cell(rand_cell());
          rand_sent++;
        end
      end
    end

    idle_on = 1'b0;
    in_valid <= 1'b0;
    drain = 0;
    while (relax.expected_relaxed.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    relax.close_out();
    $display("%0d cells in %0d frames, %0d relaxed cells checked", relax.cells, relax.frames,
             relax.results);
    $display("grids from 3x3 up to 64 wide and 24 tall, clamped, ignored and mid-frame writes");
    if (relax.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #25_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/jlss_pkg.sv
hw/rtl/jlss_position.sv
hw/rtl/jacobi_laplace_stencil_sweep_top.sv
tb/tb_jacobi_laplace_stencil_sweep_top.sv
